### design/bcomp_pkg.sv
// ----------------------------------------------------------------------------
// bcomp_pkg
// Shared types, widths and constants of the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package bcomp_pkg;

    localparam int RAW_W    = 24;
    localparam int CAL_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int DT_W     = 25;
    localparam int TEMP_W   = 19;
    localparam int TEMPC_W  = 20;
    localparam int T2_W     = 18;
    localparam int OS_W     = 40;
    localparam int SQ_W     = 36;
    localparam int TOUT_W   = 15;
    localparam int POUT_W   = 17;

    localparam int TEMP_REF  = 2000;
    localparam int TEMP_COLD = -1500;
    localparam int TEMP_MIN  = -4000;
    localparam int TEMP_MAX  = 8500;
    localparam int PRES_MIN  = 1000;
    localparam int PRES_MAX  = 120000;

    localparam logic [CFG_IDX_W-1:0] CFG_C1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_C2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_C3 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_C4 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_C5 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_C6 = 3'd5;

    typedef struct packed {
        logic [CAL_W-1:0] c1;
        logic [CAL_W-1:0] c2;
        logic [CAL_W-1:0] c3;
        logic [CAL_W-1:0] c4;
        logic [CAL_W-1:0] c5;
        logic [CAL_W-1:0] c6;
    } t_cal;

    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [TEMP_W-1:0] temp;
        logic signed [OS_W-1:0]   off;
        logic signed [OS_W-1:0]   sens;
        logic [T2_W-1:0]          t2;
    } t_first;

    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [TOUT_W-1:0] temp;
        logic signed [OS_W-1:0]   off;
        logic signed [OS_W-1:0]   sens;
    } t_corr;

endpackage

### design/bcomp_in_if.sv
// ----------------------------------------------------------------------------
// bcomp_in_if
// Request channel carrying one raw pressure/temperature conversion pair.
// ----------------------------------------------------------------------------
interface bcomp_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

### design/bcomp_out_if.sv
// ----------------------------------------------------------------------------
// bcomp_out_if
// Result channel carrying compensated temperature and pressure.
// ----------------------------------------------------------------------------
interface bcomp_out_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] temperature_centi;
    logic [16:0]        pressure_centi;

    modport source (output valid, output temperature_centi, output pressure_centi, input ready);
    modport sink   (input valid, input temperature_centi, input pressure_centi, output ready);
endinterface

### design/bcomp_cfg.sv
// ----------------------------------------------------------------------------
// bcomp_cfg
// Calibration word registers C1..C6 behind a plain write port.
// ----------------------------------------------------------------------------
module bcomp_cfg
    import bcomp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CAL_W-1:0]     i_cfg_data,
    output t_cal                 o_cal
);

    t_cal r_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_C1:  r_cal.c1 <= i_cfg_data;
                CFG_C2:  r_cal.c2 <= i_cfg_data;
                CFG_C3:  r_cal.c3 <= i_cfg_data;
                CFG_C4:  r_cal.c4 <= i_cfg_data;
                CFG_C5:  r_cal.c5 <= i_cfg_data;
                CFG_C6:  r_cal.c6 <= i_cfg_data;
                default: r_cal <= r_cal;
            endcase
        end
    end

    assign o_cal = r_cal;

endmodule

### design/bcomp_first.sv
// ----------------------------------------------------------------------------
// bcomp_first
// First-order terms: dT, products with the calibration words, TEMP, OFF,
// SENS and T2. Three register stages.
// ----------------------------------------------------------------------------
module bcomp_first
    import bcomp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cal             i_cal,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [RAW_W-1:0] i_d1,
    input  logic [RAW_W-1:0] i_d2,
    output logic             o_valid,
    input  logic             i_ready,
    output t_first           o_data
);

    logic [2:0] r_vld;
    logic [2:0] stg_en;

    logic [RAW_W-1:0]       r_s1_d1;
    logic signed [DT_W-1:0] r_s1_dt;
    logic signed [DT_W-1:0] n_s1_dt;

    logic [RAW_W-1:0]  r_s2_d1;
    logic signed [41:0] r_s2_tmul, n_s2_tmul;
    logic signed [41:0] r_s2_omul, n_s2_omul;
    logic signed [41:0] r_s2_smul, n_s2_smul;
    logic signed [49:0] r_s2_dtsq, n_s2_dtsq;

    t_first r_s3;
    t_first n_s3;
    logic signed [41:0] temp_w;
    logic signed [41:0] off_w;
    logic signed [41:0] sens_w;

    assign stg_en[2] = !r_vld[2] || i_ready;
    assign stg_en[1] = !r_vld[1] || stg_en[2];
    assign stg_en[0] = !r_vld[0] || stg_en[1];
    assign o_ready   = stg_en[0];
    assign o_valid   = r_vld[2];
    assign o_data    = r_s3;

    always_comb begin
        n_s1_dt   = $signed({1'b0, i_d2}) - $signed({1'b0, i_cal.c5, 8'd0});
        n_s2_tmul = r_s1_dt * $signed({1'b0, i_cal.c6});
        n_s2_omul = r_s1_dt * $signed({1'b0, i_cal.c4});
        n_s2_smul = r_s1_dt * $signed({1'b0, i_cal.c3});
        n_s2_dtsq = r_s1_dt * r_s1_dt;
        temp_w    = (r_s2_tmul >>> 23) + $signed(42'(TEMP_REF));
        off_w     = $signed({10'd0, i_cal.c2, 16'd0}) + (r_s2_omul >>> 7);
        sens_w    = $signed({11'd0, i_cal.c1, 15'd0}) + (r_s2_smul >>> 8);
        n_s3.d1   = r_s2_d1;
        n_s3.temp = temp_w[TEMP_W-1:0];
        n_s3.off  = off_w[OS_W-1:0];
        n_s3.sens = sens_w[OS_W-1:0];
        n_s3.t2   = r_s2_dtsq[48:31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[0]) r_vld[0] <= i_valid;
            if (stg_en[1]) r_vld[1] <= r_vld[0];
            if (stg_en[2]) r_vld[2] <= r_vld[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_s1_d1 <= i_d1;
            r_s1_dt <= n_s1_dt;
        end
        if (stg_en[1]) begin
            r_s2_d1   <= r_s1_d1;
            r_s2_tmul <= n_s2_tmul;
            r_s2_omul <= n_s2_omul;
            r_s2_smul <= n_s2_smul;
            r_s2_dtsq <= n_s2_dtsq;
        end
        if (stg_en[2]) begin
            r_s3 <= n_s3;
        end
    end

endmodule

### design/bcomp_corr.sv
// ----------------------------------------------------------------------------
// bcomp_corr
// Second-order correction below 20 C and the extra terms below -15 C,
// temperature saturation. Three register stages.
// ----------------------------------------------------------------------------
module bcomp_corr
    import bcomp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_first i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_corr  o_data
);

    logic [2:0] r_vld;
    logic [2:0] stg_en;

    logic [RAW_W-1:0]          r_s4_d1;
    logic signed [OS_W-1:0]    r_s4_off;
    logic signed [OS_W-1:0]    r_s4_sens;
    logic signed [TEMPC_W-1:0] r_s4_temp, n_s4_temp;
    logic [SQ_W-1:0]           r_s4_sq1, r_s4_sq2;
    logic                      r_s4_cold, r_s4_vcold;
    logic                      n_s4_cold, n_s4_vcold;
    logic signed [TEMPC_W-1:0] d_ref, d_cold, temp_x;
    logic signed [39:0]        sq1_w, sq2_w;

    logic [RAW_W-1:0]         r_s5_d1;
    logic signed [OS_W-1:0]   r_s5_off;
    logic signed [OS_W-1:0]   r_s5_sens;
    logic [OS_W-1:0]          r_s5_off2, n_s5_off2;
    logic [OS_W-1:0]          r_s5_sens2, n_s5_sens2;
    logic signed [TOUT_W-1:0] r_s5_temp, n_s5_temp;
    logic [OS_W-1:0]          sq1_x, sq2_x, five_sq, seven_sq, eleven_sq;

    t_corr r_s6;
    t_corr n_s6;

    assign stg_en[2] = !r_vld[2] || i_ready;
    assign stg_en[1] = !r_vld[1] || stg_en[2];
    assign stg_en[0] = !r_vld[0] || stg_en[1];
    assign o_ready   = stg_en[0];
    assign o_valid   = r_vld[2];
    assign o_data    = r_s6;

    always_comb begin
        temp_x     = TEMPC_W'(i_data.temp);
        d_ref      = temp_x - $signed(TEMPC_W'(TEMP_REF));
        d_cold     = temp_x - $signed(TEMPC_W'(TEMP_COLD));
        sq1_w      = d_ref * d_ref;
        sq2_w      = d_cold * d_cold;
        n_s4_cold  = i_data.temp < TEMP_REF;
        n_s4_vcold = i_data.temp < TEMP_COLD;
        n_s4_temp  = n_s4_cold ? temp_x - $signed({2'b00, i_data.t2}) : temp_x;

        sq1_x      = OS_W'(r_s4_sq1);
        sq2_x      = OS_W'(r_s4_sq2);
        five_sq    = (sq1_x << 2) + sq1_x;
        seven_sq   = (sq2_x << 3) - sq2_x;
        eleven_sq  = (sq2_x << 3) + (sq2_x << 1) + sq2_x;
        n_s5_off2  = (r_s4_cold ? (five_sq >> 1) : '0) + (r_s4_vcold ? seven_sq : '0);
        n_s5_sens2 = (r_s4_cold ? (five_sq >> 2) : '0) + (r_s4_vcold ? (eleven_sq >> 1) : '0);
        if (r_s4_temp < TEMP_MIN) begin
            n_s5_temp = TOUT_W'(TEMP_MIN);
        end else if (r_s4_temp > TEMP_MAX) begin
            n_s5_temp = TOUT_W'(TEMP_MAX);
        end else begin
            n_s5_temp = r_s4_temp[TOUT_W-1:0];
        end

        n_s6.d1   = r_s5_d1;
        n_s6.temp = r_s5_temp;
        n_s6.off  = r_s5_off - $signed(r_s5_off2);
        n_s6.sens = r_s5_sens - $signed(r_s5_sens2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[0]) r_vld[0] <= i_valid;
            if (stg_en[1]) r_vld[1] <= r_vld[0];
            if (stg_en[2]) r_vld[2] <= r_vld[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_s4_d1    <= i_data.d1;
            r_s4_off   <= i_data.off;
            r_s4_sens  <= i_data.sens;
            r_s4_temp  <= n_s4_temp;
            r_s4_sq1   <= sq1_w[SQ_W-1:0];
            r_s4_sq2   <= sq2_w[SQ_W-1:0];
            r_s4_cold  <= n_s4_cold;
            r_s4_vcold <= n_s4_vcold;
        end
        if (stg_en[1]) begin
            r_s5_d1    <= r_s4_d1;
            r_s5_off   <= r_s4_off;
            r_s5_sens  <= r_s4_sens;
            r_s5_off2  <= n_s5_off2;
            r_s5_sens2 <= n_s5_sens2;
            r_s5_temp  <= n_s5_temp;
        end
        if (stg_en[2]) begin
            r_s6 <= n_s6;
        end
    end

endmodule

### design/bcomp_pres.sv
// ----------------------------------------------------------------------------
// bcomp_pres
// Pressure: D1*SENS as two partial products, scaling, offset removal and
// saturation, ending in the output register. Four register stages.
// ----------------------------------------------------------------------------
module bcomp_pres
    import bcomp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  t_corr                    i_data,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [TOUT_W-1:0] o_temp,
    output logic [POUT_W-1:0]        o_pres
);

    logic [3:0] r_vld;
    logic [3:0] stg_en;

    logic signed [TOUT_W-1:0] r_s7_temp, r_s8_temp, r_s9_temp, r_s10_temp;
    logic signed [OS_W-1:0]   r_s7_off, r_s8_off;
    logic [43:0]              r_s7_lo, n_s7_lo;
    logic signed [44:0]       r_s7_hi, n_s7_hi;
    logic signed [63:0]       r_s8_prod, n_s8_prod;
    logic signed [42:0]       r_s9_q;
    logic signed [63:0]       q_w;
    logic signed [42:0]       p_w;
    logic [POUT_W-1:0]        r_s10_pres, n_s10_pres;

    assign stg_en[3] = !r_vld[3] || i_ready;
    assign stg_en[2] = !r_vld[2] || stg_en[3];
    assign stg_en[1] = !r_vld[1] || stg_en[2];
    assign stg_en[0] = !r_vld[0] || stg_en[1];
    assign o_ready   = stg_en[0];
    assign o_valid   = r_vld[3];
    assign o_temp    = r_s10_temp;
    assign o_pres    = r_s10_pres;

    always_comb begin
        n_s7_lo   = i_data.d1 * i_data.sens[19:0];
        n_s7_hi   = $signed({1'b0, i_data.d1}) * $signed(i_data.sens[OS_W-1:20]);
        n_s8_prod = ($signed(64'(r_s7_hi)) <<< 20) + $signed({20'd0, r_s7_lo});
        q_w       = (r_s8_prod >>> 21) - $signed(64'(r_s8_off));
        p_w       = r_s9_q >>> 15;
        if (p_w < PRES_MIN) begin
            n_s10_pres = POUT_W'(PRES_MIN);
        end else if (p_w > PRES_MAX) begin
            n_s10_pres = POUT_W'(PRES_MAX);
        end else begin
            n_s10_pres = p_w[POUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[0]) r_vld[0] <= i_valid;
            if (stg_en[1]) r_vld[1] <= r_vld[0];
            if (stg_en[2]) r_vld[2] <= r_vld[1];
            if (stg_en[3]) r_vld[3] <= r_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_s7_temp <= i_data.temp;
            r_s7_off  <= i_data.off;
            r_s7_lo   <= n_s7_lo;
            r_s7_hi   <= n_s7_hi;
        end
        if (stg_en[1]) begin
            r_s8_temp <= r_s7_temp;
            r_s8_off  <= r_s7_off;
            r_s8_prod <= n_s8_prod;
        end
        if (stg_en[2]) begin
            r_s9_temp <= r_s8_temp;
            r_s9_q    <= q_w[42:0];
        end
        if (stg_en[3]) begin
            r_s10_temp <= r_s9_temp;
            r_s10_pres <= n_s10_pres;
        end
    end

endmodule

### design/barometric_compensation_top.sv
// ----------------------------------------------------------------------------
// barometric_compensation_top
// Second-order compensated barometer: raw D1/D2 conversions in, temperature
// in 0.01 C and pressure in 0.01 mbar out, saturated to rated ranges.
//
//   channel   direction  payload                                  handshake
//   i_meas    in         raw_pressure[23:0], raw_temperature[23:0] valid/ready
//   o_res     out        temperature_centi[14:0] s, pressure_centi[16:0] valid/ready
//   cfg       in         i_cfg_idx[2:0], i_cfg_data[15:0]          i_cfg_we
//
// One request per cycle while the output is not stalled; ten register stages
// (three first-order, three correction, four pressure stages).
// Every stage carries a valid bit; a stage holds while its successor is full
// and stalled, so bubbles fill up and a stalled result holds its value.
// Reset clears all valid bits and the calibration words to zero.
// ----------------------------------------------------------------------------
module barometric_compensation_top
    import bcomp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bcomp_in_if.sink             i_meas,
    bcomp_out_if.source          o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CAL_W-1:0]     i_cfg_data
);

    t_cal   cal;
    t_first first_data;
    logic   first_valid, first_ready;
    t_corr  corr_data;
    logic   corr_valid, corr_ready;

    bcomp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cal      (cal)
    );

    bcomp_first u_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cal   (cal),
        .i_valid (i_meas.valid),
        .o_ready (i_meas.ready),
        .i_d1    (i_meas.raw_pressure),
        .i_d2    (i_meas.raw_temperature),
        .o_valid (first_valid),
        .i_ready (first_ready),
        .o_data  (first_data)
    );

    bcomp_corr u_corr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (first_valid),
        .o_ready (first_ready),
        .i_data  (first_data),
        .o_valid (corr_valid),
        .i_ready (corr_ready),
        .o_data  (corr_data)
    );

    bcomp_pres u_pres (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (corr_valid),
        .o_ready (corr_ready),
        .i_data  (corr_data),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_temp  (o_res.temperature_centi),
        .o_pres  (o_res.pressure_centi)
    );

endmodule
